>>> sv/gyhc_pkg.sv
// Package for the gyro heading controller: constants, types and angle helpers.
package gyhc_pkg;

   // Fixed-point formats
   localparam int ANGLE_FRAC_BITS = 12;
   localparam int SPEED_FRAC_BITS = 8;
   localparam int GAIN_FRAC_BITS  = 8;
   localparam int DRIVE_SHIFT     = GAIN_FRAC_BITS + ANGLE_FRAC_BITS - SPEED_FRAC_BITS;

   // pi at 20 fraction bits, rounded to nearest in the angle format
   localparam int PI_Q20 = 3294199;
   localparam int PI_Q   = ((PI_Q20 >> (20 - ANGLE_FRAC_BITS - 1)) + 1) >> 1;

   // Field widths
   localparam int RATE_W    = 16;
   localparam int TICK_W    = 8;
   localparam int SEG_W     = 16;
   localparam int GAIN_W    = 16;
   localparam int BASE_W    = 16;
   localparam int MAX_W     = 15;
   localparam int SPEED_W   = 16;
   localparam int HEAD_O_W  = 15;
   localparam int ELAPSED_W = 20;
   localparam int TIDX_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Stored heading and heading error
   localparam int ANG_W = 16;

   // Shared multiplier operand and product widths
   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;

   // Rate times tick: signed product and its magnitude
   localparam int RT_W  = RATE_W + TICK_W;
   localparam int MAG_W = RT_W - 1;

   // Divide by 1000 as multiply by ceil(2^33 / 1000), exact for MAG_W-bit values
   localparam int RECIP_SHIFT = 33;
   localparam int RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 24'd8589935;
   localparam int QUOT_W      = 14;

   // Steering drive after the gain product is scaled
   localparam int GPROD_W = 32;
   localparam int DRV_W   = GPROD_W - DRIVE_SHIFT;
   localparam int SUM_W   = DRV_W + 1;

   // Angle constants at working widths
   localparam logic signed [ANG_W:0]   PI_WIDE     = (ANG_W + 1)'(PI_Q);
   localparam logic signed [ANG_W:0]   TWO_PI_WIDE = (ANG_W + 1)'(2 * PI_Q);
   localparam logic signed [ANG_W-1:0] PI_ANG      = ANG_W'(PI_Q);
   localparam logic signed [ANG_W-1:0] HALF_PI_ANG = ANG_W'(PI_Q >> 1);

   // Register reset values
   localparam logic [TICK_W-1:0]        TICK_MS_RST    = 8'd64;
   localparam logic [SEG_W-1:0]         SEGMENT_MS_RST = 16'd2500;
   localparam logic [GAIN_W-1:0]        KP_GAIN_RST    = 16'd3840;
   localparam logic signed [BASE_W-1:0] BASE_SPEED_RST = 16'sd2145;
   localparam logic [MAX_W-1:0]         MAX_SPEED_RST  = 15'd2145;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_MS    = 3'd0,
      CSR_SEGMENT_MS = 3'd1,
      CSR_KP_GAIN    = 3'd2,
      CSR_BASE_SPEED = 3'd3,
      CSR_MAX_SPEED  = 3'd4
   } csr_index_type;

   // Target schedule codes
   typedef enum logic [TIDX_W-1:0] {
      TGT_ZERO     = 2'd0,
      TGT_HALF_PI  = 2'd1,
      TGT_PI       = 2'd2,
      TGT_NEG_HALF = 2'd3
   } target_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_RATE,
      ST_MUL_RECIP,
      ST_HEAD,
      ST_ERR,
      ST_MUL_GAIN,
      ST_OUT
   } state_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      MSEL_RATE,
      MSEL_RECIP,
      MSEL_GAIN
   } mul_sel_type;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [TICK_W-1:0]        tick_ms;
      logic [SEG_W-1:0]         segment_ms;
      logic [GAIN_W-1:0]        kp_gain;
      logic signed [BASE_W-1:0] base_speed;
      logic [MAX_W-1:0]         max_speed;
   } cfg_type;

   // Sequencer controls to the datapath
   typedef struct packed {
      logic        busy;
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        head_en;
      logic        err_en;
      logic        out_en;
   } ctrl_type;

   // Wrap an angle once into [-pi, pi]
   function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W:0] a);
      logic signed [ANG_W:0] r;
      if (a > PI_WIDE) begin
         r = a - TWO_PI_WIDE;
      end else if (a < -PI_WIDE) begin
         r = a + TWO_PI_WIDE;
      end else begin
         r = a;
      end
      return r[ANG_W-1:0];
   endfunction

   // Target angle for a schedule code
   function automatic logic signed [ANG_W-1:0] target_angle(input logic [TIDX_W-1:0] idx);
      logic signed [ANG_W-1:0] t;
      unique case (target_type'(idx))
         TGT_HALF_PI:  t = HALF_PI_ANG;
         TGT_PI:       t = PI_ANG;
         TGT_NEG_HALF: t = -HALF_PI_ANG;
         default:      t = '0;
      endcase
      return t;
   endfunction

endpackage

>>> sv/gyro_heading_p_controller.sv
// Top level of the gyro heading proportional controller.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_gyro_rate
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_left_speed, rsp_right_speed,
//          |           |                      | rsp_heading, rsp_target_heading
//  csr     | in        | csr_write            | csr_index, csr_wdata
//
// An item goes from acceptance to result through MUL_RATE, MUL_RECIP, HEAD, ERR,
// MUL_GAIN and OUT, and no new item is taken until it is through: one multiplier
// is issued three times per item (rate times tick, reciprocal of 1000, gain times
// error). Reset is synchronous, clears the heading and the schedule and resets the
// registers. A stalled result holds in the output register; the next item is
// accepted meanwhile and waits in its last step until the register frees.
module gyro_heading_p_controller (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [gyhc_pkg::RATE_W-1:0]       req_gyro_rate,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [gyhc_pkg::SPEED_W-1:0]      rsp_left_speed,
   output logic signed [gyhc_pkg::SPEED_W-1:0]      rsp_right_speed,
   output logic signed [gyhc_pkg::HEAD_O_W-1:0]     rsp_heading,
   output logic signed [gyhc_pkg::HEAD_O_W-1:0]     rsp_target_heading,
   input  logic                                     csr_write,
   input  logic [gyhc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [gyhc_pkg::CSR_DAT_W-1:0]           csr_wdata
);

   gyhc_pkg::cfg_type  cfg;
   gyhc_pkg::ctrl_type ctrl;
   logic               out_free;

   logic signed [gyhc_pkg::MUL_W-1:0]  mul_a;
   logic signed [gyhc_pkg::MUL_W-1:0]  mul_b;
   logic signed [gyhc_pkg::PROD_W-1:0] prod;

   logic signed [gyhc_pkg::RATE_W-1:0]  rate_ff;
   logic                                neg_ff;
   logic signed [gyhc_pkg::ANG_W-1:0]   head_ff;
   logic signed [gyhc_pkg::ANG_W-1:0]   head_in;
   logic signed [gyhc_pkg::ANG_W-1:0]   err_ff;
   logic signed [gyhc_pkg::ANG_W-1:0]   err_in;
   logic [gyhc_pkg::ELAPSED_W-1:0]      elapsed_ff;
   logic [gyhc_pkg::ELAPSED_W-1:0]      elapsed_in;
   logic [gyhc_pkg::TIDX_W-1:0]         tidx_ff;
   logic [gyhc_pkg::TIDX_W-1:0]         tidx_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic signed [gyhc_pkg::SPEED_W-1:0]  left_ff;
   logic signed [gyhc_pkg::SPEED_W-1:0]  right_ff;
   logic signed [gyhc_pkg::HEAD_O_W-1:0] heading_ff;
   logic signed [gyhc_pkg::HEAD_O_W-1:0] target_ff;

   logic signed [gyhc_pkg::RT_W-1:0]    rt_prod;
   logic [gyhc_pkg::RT_W-1:0]           rt_neg;
   logic [gyhc_pkg::MAG_W-1:0]          rt_mag;
   logic [gyhc_pkg::QUOT_W-1:0]         quot;
   logic signed [gyhc_pkg::ANG_W-1:0]   quot_s;
   logic signed [gyhc_pkg::ANG_W-1:0]   delta;
   logic signed [gyhc_pkg::ANG_W:0]     head_sum;
   logic signed [gyhc_pkg::ANG_W-1:0]   tgt;
   logic signed [gyhc_pkg::ANG_W:0]     err_sum;
   logic signed [gyhc_pkg::GPROD_W-1:0] gprod;
   logic signed [gyhc_pkg::GPROD_W-1:0] gprod_b;
   logic signed [gyhc_pkg::DRV_W-1:0]   drive;
   logic signed [gyhc_pkg::SUM_W-1:0]   right_sum;
   logic signed [gyhc_pkg::SUM_W-1:0]   left_sum;
   logic [gyhc_pkg::ELAPSED_W-1:0]      seg1;
   logic [gyhc_pkg::ELAPSED_W-1:0]      seg2;
   logic [gyhc_pkg::ELAPSED_W-1:0]      seg3;
   logic [gyhc_pkg::ELAPSED_W-1:0]      seg4;

   // Clamp a speed sum to the symmetric limit
   function automatic logic signed [gyhc_pkg::SPEED_W-1:0] clamp_speed(
      input logic signed [gyhc_pkg::SUM_W-1:0] v,
      input logic [gyhc_pkg::MAX_W-1:0]        lim_u
   );
      logic signed [gyhc_pkg::SUM_W-1:0] lim;
      logic signed [gyhc_pkg::SUM_W-1:0] r;
      lim = gyhc_pkg::SUM_W'(lim_u);
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r[gyhc_pkg::SPEED_W-1:0];
   endfunction

   gyhc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gyhc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   gyhc_mul u_mul (
      .clock (clock),
      .en    (ctrl.mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = ctrl.busy;

   // Magnitude of rate times tick for the divide by 1000
   assign rt_prod = prod[gyhc_pkg::RT_W-1:0];
   assign rt_neg  = -rt_prod;
   assign rt_mag  = rt_prod[gyhc_pkg::RT_W-1] ? rt_neg[gyhc_pkg::MAG_W-1:0]
                                              : rt_prod[gyhc_pkg::MAG_W-1:0];

   // Select multiplier operands
   always_comb begin
      unique case (ctrl.mul_sel)
         gyhc_pkg::MSEL_RATE: begin
            mul_a = gyhc_pkg::MUL_W'(rate_ff);
            mul_b = gyhc_pkg::MUL_W'(cfg.tick_ms);
         end
         gyhc_pkg::MSEL_RECIP: begin
            mul_a = gyhc_pkg::MUL_W'(rt_mag);
            mul_b = gyhc_pkg::MUL_W'(gyhc_pkg::RECIP_1000);
         end
         gyhc_pkg::MSEL_GAIN: begin
            mul_a = gyhc_pkg::MUL_W'(cfg.kp_gain);
            mul_b = gyhc_pkg::MUL_W'(err_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Heading step: quotient, signed, added and wrapped
   assign quot     = prod[gyhc_pkg::RECIP_SHIFT +: gyhc_pkg::QUOT_W];
   assign quot_s   = gyhc_pkg::ANG_W'(quot);
   assign delta    = neg_ff ? -quot_s : quot_s;
   assign head_sum = (gyhc_pkg::ANG_W + 1)'(head_ff) + (gyhc_pkg::ANG_W + 1)'(delta);
   assign head_in  = gyhc_pkg::wrap_angle(head_sum);

   // Heading error to the current target, wrapped
   assign tgt     = gyhc_pkg::target_angle(tidx_ff);
   assign err_sum = (gyhc_pkg::ANG_W + 1)'(tgt) - (gyhc_pkg::ANG_W + 1)'(head_ff);
   assign err_in  = gyhc_pkg::wrap_angle(err_sum);

   // Drive: gain product scaled down, truncated toward zero
   assign gprod   = prod[gyhc_pkg::GPROD_W-1:0];
   assign gprod_b = gprod + (gprod[gyhc_pkg::GPROD_W-1]
                     ? gyhc_pkg::GPROD_W'((1 << gyhc_pkg::DRIVE_SHIFT) - 1)
                     : gyhc_pkg::GPROD_W'(0));
   assign drive   = gprod_b[gyhc_pkg::GPROD_W-1:gyhc_pkg::DRIVE_SHIFT];

   // Wheel speeds before the clamp
   assign right_sum = gyhc_pkg::SUM_W'(cfg.base_speed) + gyhc_pkg::SUM_W'(drive);
   assign left_sum  = gyhc_pkg::SUM_W'(cfg.base_speed) - gyhc_pkg::SUM_W'(drive);

   // Schedule thresholds
   assign seg1 = gyhc_pkg::ELAPSED_W'(cfg.segment_ms);
   assign seg2 = seg1 << 1;
   assign seg3 = seg1 + seg2;
   assign seg4 = seg1 << 2;

   // Advance the elapsed time and step the target schedule
   always_comb begin
      elapsed_in = elapsed_ff;
      tidx_in    = tidx_ff;
      if (ctrl.head_en) begin
         elapsed_in = elapsed_ff + gyhc_pkg::ELAPSED_W'(cfg.tick_ms);
      end else if (ctrl.out_en) begin
         priority if (elapsed_ff > seg4) begin
            tidx_in    = gyhc_pkg::TGT_ZERO;
            elapsed_in = '0;
         end else if (elapsed_ff > seg3) begin
            tidx_in = gyhc_pkg::TGT_NEG_HALF;
         end else if (elapsed_ff > seg2) begin
            tidx_in = gyhc_pkg::TGT_PI;
         end else if (elapsed_ff > seg1) begin
            tidx_in = gyhc_pkg::TGT_HALF_PI;
         end else begin
            tidx_in = tidx_ff;
         end
      end
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         elapsed_ff   <= '0;
         tidx_ff      <= gyhc_pkg::TGT_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.head_en) begin
            head_ff <= head_in;
         end
         elapsed_ff   <= elapsed_in;
         tidx_ff      <= tidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         rate_ff <= req_gyro_rate;
      end
      if (ctrl.mul_en && (ctrl.mul_sel == gyhc_pkg::MSEL_RECIP)) begin
         neg_ff <= rt_prod[gyhc_pkg::RT_W-1];
      end
      if (ctrl.err_en) begin
         err_ff <= err_in;
      end
      if (ctrl.out_en) begin
         left_ff    <= clamp_speed(left_sum, cfg.max_speed);
         right_ff   <= clamp_speed(right_sum, cfg.max_speed);
         heading_ff <= head_ff[gyhc_pkg::HEAD_O_W-1:0];
         target_ff  <= tgt[gyhc_pkg::HEAD_O_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_speed     = left_ff;
   assign rsp_right_speed    = right_ff;
   assign rsp_heading        = heading_ff;
   assign rsp_target_heading = target_ff;

endmodule

>>> sv/gyhc_mul.sv
// Shared signed multiplier with a registered product.
module gyhc_mul (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [gyhc_pkg::MUL_W-1:0]    a,
   input  logic signed [gyhc_pkg::MUL_W-1:0]    b,
   output logic signed [gyhc_pkg::PROD_W-1:0]   prod
);

   logic signed [gyhc_pkg::PROD_W-1:0] prod_ff;
   logic signed [gyhc_pkg::PROD_W-1:0] prod_in;

   // Form the product
   assign prod_in = gyhc_pkg::PROD_W'(a) * gyhc_pkg::PROD_W'(b);

   // Hold the product until the next issue
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> sv/gyhc_csr.sv
// Configuration register file for the gyro heading controller.
module gyhc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [gyhc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gyhc_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output gyhc_pkg::cfg_type                  cfg
);

   gyhc_pkg::cfg_type cfg_ff;
   gyhc_pkg::cfg_type cfg_in;

   // Decode the write; drop writes to unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (gyhc_pkg::csr_index_type'(csr_index))
            gyhc_pkg::CSR_TICK_MS:    cfg_in.tick_ms    = csr_wdata[gyhc_pkg::TICK_W-1:0];
            gyhc_pkg::CSR_SEGMENT_MS: cfg_in.segment_ms = csr_wdata[gyhc_pkg::SEG_W-1:0];
            gyhc_pkg::CSR_KP_GAIN:    cfg_in.kp_gain    = csr_wdata[gyhc_pkg::GAIN_W-1:0];
            gyhc_pkg::CSR_BASE_SPEED: cfg_in.base_speed = csr_wdata[gyhc_pkg::BASE_W-1:0];
            gyhc_pkg::CSR_MAX_SPEED:  cfg_in.max_speed  = csr_wdata[gyhc_pkg::MAX_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // Store the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_ms    <= gyhc_pkg::TICK_MS_RST;
         cfg_ff.segment_ms <= gyhc_pkg::SEGMENT_MS_RST;
         cfg_ff.kp_gain    <= gyhc_pkg::KP_GAIN_RST;
         cfg_ff.base_speed <= gyhc_pkg::BASE_SPEED_RST;
         cfg_ff.max_speed  <= gyhc_pkg::MAX_SPEED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/gyhc_seq.sv
// Sequencer that steps one item through the shared multiplier and datapath.
module gyhc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                out_free,
   output gyhc_pkg::ctrl_type  ctrl
);

   gyhc_pkg::state_type state_ff;
   gyhc_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gyhc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = gyhc_pkg::ST_MUL_RATE;
            end
         end
         gyhc_pkg::ST_MUL_RATE:  state_in = gyhc_pkg::ST_MUL_RECIP;
         gyhc_pkg::ST_MUL_RECIP: state_in = gyhc_pkg::ST_HEAD;
         gyhc_pkg::ST_HEAD:      state_in = gyhc_pkg::ST_ERR;
         gyhc_pkg::ST_ERR:       state_in = gyhc_pkg::ST_MUL_GAIN;
         gyhc_pkg::ST_MUL_GAIN:  state_in = gyhc_pkg::ST_OUT;
         gyhc_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = gyhc_pkg::ST_IDLE;
            end
         end
         default: state_in = gyhc_pkg::ST_IDLE;
      endcase
   end

   // Controls per state
   always_comb begin
      ctrl         = '0;
      ctrl.mul_sel = gyhc_pkg::MSEL_RATE;
      ctrl.busy    = (state_ff != gyhc_pkg::ST_IDLE);
      unique case (state_ff)
         gyhc_pkg::ST_IDLE:      ctrl.capture = req_valid;
         gyhc_pkg::ST_MUL_RATE: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = gyhc_pkg::MSEL_RATE;
         end
         gyhc_pkg::ST_MUL_RECIP: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = gyhc_pkg::MSEL_RECIP;
         end
         gyhc_pkg::ST_HEAD:      ctrl.head_en = 1'b1;
         gyhc_pkg::ST_ERR:       ctrl.err_en  = 1'b1;
         gyhc_pkg::ST_MUL_GAIN: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = gyhc_pkg::MSEL_GAIN;
         end
         gyhc_pkg::ST_OUT:       ctrl.out_en  = out_free;
         default:                ctrl.busy    = 1'b1;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gyhc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/gyhc_checker.sv
// Port-level checks for the gyro heading controller, bound to the top level.
module gyhc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [gyhc_pkg::SPEED_W-1:0]    rsp_left_speed,
   input logic signed [gyhc_pkg::SPEED_W-1:0]    rsp_right_speed,
   input logic signed [gyhc_pkg::HEAD_O_W-1:0]   rsp_heading,
   input logic signed [gyhc_pkg::HEAD_O_W-1:0]   rsp_target_heading
);

   localparam logic signed [gyhc_pkg::HEAD_O_W-1:0] PI_O   = gyhc_pkg::HEAD_O_W'(gyhc_pkg::PI_Q);
   localparam logic signed [gyhc_pkg::HEAD_O_W-1:0] HALF_O = gyhc_pkg::HEAD_O_W'(gyhc_pkg::PI_Q >> 1);

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_left_speed) &&
      $stable(rsp_right_speed) && $stable(rsp_heading) && $stable(rsp_target_heading)))
      else $error("stalled result changed");

   // One item at a time: busy after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted back to back");

   // Heading stays wrapped and the target is one of the schedule angles
   a_angles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_heading <= PI_O) && (rsp_heading >= -PI_O) &&
      ((rsp_target_heading == '0) || (rsp_target_heading == HALF_O) ||
       (rsp_target_heading == PI_O) || (rsp_target_heading == -HALF_O))))
      else $error("heading or target out of range");

endmodule

bind gyro_heading_p_controller gyhc_checker u_gyhc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_left_speed     (rsp_left_speed),
   .rsp_right_speed    (rsp_right_speed),
   .rsp_heading        (rsp_heading),
   .rsp_target_heading (rsp_target_heading)
);
